FILE: src/polyhedral_region_locator_macros.svh
// assertion macros for the region locator checker
`ifndef POLYHEDRAL_REGION_LOCATOR_MACROS_SVH
`define POLYHEDRAL_REGION_LOCATOR_MACROS_SVH
`define PRL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PRL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: src/prl_pkg.sv
`timescale 1ns / 1ps
package prl_pkg;
   typedef enum logic [1:0] {
      OP_ROW   = 2'd0,
      OP_COUNT = 2'd1,
      OP_LOCATE = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      BY_CURRENT   = 3'd0,
      BY_PREV_SET  = 3'd1,
      BY_PREV_POLY = 3'd2,
      BY_SEARCH    = 3'd3,
      BY_NONE      = 3'd4
   } decided_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WAIT,
      ST_DONE
   } state_type;

   localparam int LANES = 4;
   localparam logic [1:0] PH_CUR = 2'd0;
   localparam logic [1:0] PH_PSET = 2'd1;
   localparam logic [1:0] PH_PPOLY = 2'd2;
   localparam logic [1:0] PH_SEARCH = 2'd3;
endpackage

FILE: src/prl_if.sv
`timescale 1ns / 1ps
interface prl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [2:0]  set_index;
   logic [3:0]  poly_index;
   logic [3:0]  row_index;
   logic signed [31:0] value_0;
   logic signed [31:0] value_1;
   logic signed [31:0] value_2;
   logic signed [31:0] value_3;
   logic signed [31:0] row_bound;
   logic        row_enable;
   logic [4:0]  poly_count;
   modport source (output valid, opcode, set_index, poly_index, row_index, value_0,
      value_1, value_2, value_3, row_bound, row_enable, poly_count, input ready);
   modport sink (input valid, opcode, set_index, poly_index, row_index, value_0,
      value_1, value_2, value_3, row_bound, row_enable, poly_count, output ready);
endinterface

interface prl_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] found_set;
   logic [3:0] found_poly;
   logic       found;
   logic [2:0] decided_by;
   modport source (output valid, found_set, found_poly, found, decided_by, input ready);
   modport sink (input valid, found_set, found_poly, found, decided_by, output ready);
endinterface

FILE: src/prl_lane.sv
`timescale 1ns / 1ps
// one row test: a.x <= b exactly, two stages (products, then sum and compare)
module prl_lane
   import prl_pkg::*;
#(
   parameter int DIM = 4
) (
   input  logic clock,
   input  logic in_valid,
   input  logic in_enable,
   input  logic signed [31:0] coef [DIM],
   input  logic signed [31:0] bound,
   input  logic signed [31:0] x [DIM],
   output logic out_fail
);
   logic signed [63:0] prod_ff [DIM];
   logic signed [63:0] bnd_ff;
   logic               act_ff;
   logic signed [65:0] sum;

   always_ff @(posedge clock) begin
      for (int d = 0; d < DIM; d++) prod_ff[d] <= coef[d] * x[d];
      bnd_ff <= {{16{bound[31]}}, bound, 16'd0};
      act_ff <= in_valid && in_enable;
   end

   always_comb begin
      sum = '0;
      for (int d = 0; d < DIM; d++) sum = sum + 66'(prod_ff[d]);
   end

   assign out_fail = act_ff && (sum > 66'(bnd_ff));
endmodule

FILE: src/polyhedral_region_locator.sv
`timescale 1ns / 1ps
// polyhedral region locator: a table of polyhedra grouped in sets, each polyhedron holding
// up to MAX_ROWS rows a.x <= b in q16.16, tested exactly. row and count loads give no
// result. a locate item tests candidates in order: the current polyhedron, the same
// polyhedron in the previous set, the previous polyhedron in the same set, then every
// table slot set by set. four lanes each read one row of a four-row group per cycle; a
// candidate's row groups pass through the memory read register and the lane stage, then
// a drain step and a decision step. the search visits all MAX_SETS*MAX_POLYS slots and
// out-of-range ones count as misses. the result waits until the output register is free
// or being read, and the next item is taken once the result has entered that register.
// after reset a pass clears the row enable marks, during which no item is taken
module polyhedral_region_locator
   import prl_pkg::*;
#(
   parameter int DIM = 4,
   parameter int MAX_SETS = 8,
   parameter int MAX_POLYS = 16,
   parameter int MAX_ROWS = 16
) (
   input  logic clock,
   input  logic reset,
   prl_req_if.sink   req,
   prl_rsp_if.source rsp,
   input  logic       csr_psel,
   input  logic       csr_penable,
   input  logic       csr_pwrite,
   input  logic [1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic       csr_pready
);
   localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int PW = (MAX_POLYS > 1) ? $clog2(MAX_POLYS) : 1;
   localparam int GROUPS = (MAX_ROWS + LANES - 1) / LANES;
   localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int DEPTH = MAX_SETS * MAX_POLYS * GROUPS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(LANES);

   // per-lane row memories, one row group per address
   logic [32*DIM-1:0] coef_mem [LANES][DEPTH];
   logic [31:0]       bnd_mem  [LANES][DEPTH];
   logic [32*DIM-1:0] coef_rd_ff [LANES];
   logic [31:0]       bnd_rd_ff  [LANES];
   logic [LANES-1:0]  en_rd_ff;

   // enable marks cleared by a pass after reset
   logic [AW:0] clr_ff, clr_in;
   logic        clearing;

   logic [3:0] nsets_ff;
   logic [4:0] cnt_ff [MAX_SETS];

   state_type   state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [SW-1:0] cs_ff, ts_ff, ts_in;
   logic [PW-1:0] cp_ff, tp_ff, tp_in;
   logic [GW:0]   g_ff, g_in;
   logic          fail_ff, fail_in;
   logic signed [31:0] x_ff [DIM];

   logic [2:0] o_set_ff; logic [3:0] o_poly_ff; logic o_found_ff; logic [2:0] o_by_ff;
   logic o_valid_ff;

   wire acc = req.valid && req.ready;
   wire row_wr = acc && req.opcode == OP_ROW && 32'(req.set_index) < MAX_SETS &&
      32'(req.poly_index) < MAX_POLYS && 32'(req.row_index) < MAX_ROWS;
   wire [AW-1:0] wr_addr = AW'((32'(req.set_index) * MAX_POLYS + 32'(req.poly_index))
      * GROUPS + 32'(req.row_index) / LANES);
   wire [LW-1:0] wr_lane = LW'(32'(req.row_index) % LANES);

   assign clearing = clr_ff < (AW+1)'(DEPTH);
   assign req.ready = (state_ff == ST_IDLE) && !clearing;
   assign csr_pready = 1'b1;
   assign csr_prdata = {28'd0, nsets_ff};

   // active set and polyhedron limits
   logic [SW:0] act_sets;
   assign act_sets = (32'(nsets_ff) > MAX_SETS) ? (SW+1)'(MAX_SETS) : (SW+1)'(nsets_ff);
   function automatic logic [PW:0] pcount(input logic [4:0] c);
      return (32'(c) > MAX_POLYS) ? (PW+1)'(MAX_POLYS) : (PW+1)'(c);
   endfunction
   wire in_range = ({1'b0, ts_ff} < act_sets) && ({1'b0, tp_ff} < pcount(cnt_ff[ts_ff]));

   wire [AW-1:0] rd_addr = AW'((32'(ts_ff) * MAX_POLYS + 32'(tp_ff)) * GROUPS
      + 32'(g_ff[GW-1:0]));
   wire reading = (state_ff == ST_CHECK) && (32'(g_ff) < GROUPS);

   // memories
   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         if (row_wr && wr_lane == LW'(l)) begin
            coef_mem[l][wr_addr] <= {req.value_3, req.value_2, req.value_1, req.value_0};
            bnd_mem[l][wr_addr]  <= req.row_bound;
         end
         coef_rd_ff[l] <= coef_mem[l][rd_addr];
         bnd_rd_ff[l]  <= bnd_mem[l][rd_addr];
      end
   end

   // enable marks, one bit per row in each lane
   logic en_mem_l [LANES][DEPTH];
   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         if (clearing) en_mem_l[l][clr_ff[AW-1:0]] <= 1'b0;
         else if (row_wr && wr_lane == LW'(l)) en_mem_l[l][wr_addr] <= req.row_enable;
         en_rd_ff[l] <= en_mem_l[l][rd_addr];
      end
   end

   assign clr_in = clearing ? clr_ff + 1'b1 : clr_ff;

   // read valid pipeline: memory read, lane stage
   logic rv1_ff, rv2_ff;
   logic [LANES-1:0] lane_fail;
   genvar gl;
   generate
      for (gl = 0; gl < LANES; gl++) begin : g_lane
         logic signed [31:0] cf [DIM];
         for (genvar d = 0; d < DIM; d++) begin : g_d
            assign cf[d] = coef_rd_ff[gl][32*d +: 32];
         end
         prl_lane #(.DIM(DIM)) u_lane (
            .clock(clock), .in_valid(rv1_ff), .in_enable(en_rd_ff[gl]), .coef(cf),
            .bound(bnd_rd_ff[gl]), .x(x_ff), .out_fail(lane_fail[gl]));
      end
   endgenerate

   // merge: any lane fail marks the polyhedron as not containing x
   wire grp_fail = rv2_ff && (|lane_fail);

   // next state
   logic last_cand;
   always_comb begin
      state_in = state_ff; phase_in = phase_ff; ts_in = ts_ff; tp_in = tp_ff;
      g_in = g_ff; fail_in = fail_ff | grp_fail; last_cand = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (acc && req.opcode == OP_LOCATE) begin
               state_in = ST_CHECK; phase_in = PH_CUR; ts_in = req.set_index[SW-1:0];
               tp_in = req.poly_index[PW-1:0]; g_in = '0; fail_in = 1'b0;
            end
         end
         ST_CHECK: begin
            if (32'(g_ff) < GROUPS + 2) g_in = g_ff + 1'b1;
            else state_in = ST_WAIT;
         end
         ST_WAIT: begin
            state_in = ST_CHECK; g_in = '0; fail_in = 1'b0;
            if (in_range && !fail_ff) state_in = ST_DONE;
            else begin
               case (phase_ff)
                  PH_CUR: begin
                     if (cs_ff != '0) begin phase_in = PH_PSET; ts_in = cs_ff - 1'b1;
                        tp_in = cp_ff; end
                     else if (cp_ff != '0) begin phase_in = PH_PPOLY; ts_in = cs_ff;
                        tp_in = cp_ff - 1'b1; end
                     else begin phase_in = PH_SEARCH; ts_in = '0; tp_in = '0; end
                  end
                  PH_PSET: begin
                     if (cp_ff != '0) begin phase_in = PH_PPOLY; ts_in = cs_ff;
                        tp_in = cp_ff - 1'b1; end
                     else begin phase_in = PH_SEARCH; ts_in = '0; tp_in = '0; end
                  end
                  PH_PPOLY: begin phase_in = PH_SEARCH; ts_in = '0; tp_in = '0; end
                  default: begin
                     if (32'(tp_ff) + 1 < MAX_POLYS) tp_in = tp_ff + 1'b1;
                     else begin
                        tp_in = '0;
                        if (32'(ts_ff) + 1 < MAX_SETS) ts_in = ts_ff + 1'b1;
                        else last_cand = 1'b1;
                     end
                     if (last_cand) state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DONE: if (!o_valid_ff || rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; clr_ff <= '0; nsets_ff <= '0; o_valid_ff <= 1'b0;
         rv1_ff <= 1'b0; rv2_ff <= 1'b0;
         for (int s = 0; s < MAX_SETS; s++) cnt_ff[s] <= '0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in;
         rv1_ff <= reading; rv2_ff <= rv1_ff;
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0)
            nsets_ff <= csr_pwdata[3:0];
         if (acc && req.opcode == OP_COUNT && 32'(req.set_index) < MAX_SETS)
            cnt_ff[req.set_index[SW-1:0]] <= (32'(req.poly_count) > MAX_POLYS) ?
               5'(MAX_POLYS) : req.poly_count;
         if (rsp.valid && rsp.ready) o_valid_ff <= 1'b0;
         if (state_ff == ST_DONE && (!o_valid_ff || rsp.ready)) o_valid_ff <= 1'b1;
      end
   end

   // result captured when the walk ends
   logic [2:0] res_set; logic [3:0] res_poly; logic res_found; logic [2:0] res_by;
   always_ff @(posedge clock) begin
      phase_ff <= phase_in; ts_ff <= ts_in; tp_ff <= tp_in; g_ff <= g_in;
      fail_ff <= fail_in;
      if (acc && req.opcode == OP_LOCATE) begin
         cs_ff <= req.set_index[SW-1:0]; cp_ff <= req.poly_index[PW-1:0];
         x_ff[0] <= req.value_0;
         if (DIM > 1) x_ff[1 % DIM] <= req.value_1;
         if (DIM > 2) x_ff[2 % DIM] <= req.value_2;
         if (DIM > 3) x_ff[3 % DIM] <= req.value_3;
      end
      if (state_ff == ST_WAIT) begin
         res_found <= in_range && !fail_ff;
         res_set <= (in_range && !fail_ff) ? 3'(ts_ff) : 3'(cs_ff);
         res_poly <= (in_range && !fail_ff) ? 4'(tp_ff) : 4'(cp_ff);
         res_by <= !(in_range && !fail_ff) ? BY_NONE :
            (phase_ff == PH_CUR) ? BY_CURRENT : (phase_ff == PH_PSET) ? BY_PREV_SET :
            (phase_ff == PH_PPOLY) ? BY_PREV_POLY : BY_SEARCH;
      end
      if (state_ff == ST_DONE && (!o_valid_ff || rsp.ready)) begin
         o_set_ff <= res_set; o_poly_ff <= res_poly; o_found_ff <= res_found;
         o_by_ff <= res_by;
      end
   end

   assign rsp.valid = o_valid_ff;
   assign rsp.found_set = o_set_ff;
   assign rsp.found_poly = o_poly_ff;
   assign rsp.found = o_found_ff;
   assign rsp.decided_by = o_by_ff;
endmodule

FILE: src/prl_checker.sv
`timescale 1ns / 1ps
`include "polyhedral_region_locator_macros.svh"
module prl_checker
   import prl_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_found,
   input logic [2:0] rsp_decided_by
);
   `PRL_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid)
   `PRL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `PRL_ASSERT_IMPL(a_found_code, clock, reset, rsp_valid && rsp_found, rsp_decided_by != BY_NONE)
   `PRL_ASSERT_IMPL(a_none_code, clock, reset, rsp_valid && !rsp_found, rsp_decided_by == BY_NONE)
endmodule

bind polyhedral_region_locator prl_checker u_prl_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_found(rsp.found),
   .rsp_decided_by(rsp.decided_by));

FILE: tb/polyhedral_region_locator_tb.sv
`timescale 1ns / 1ps
module polyhedral_region_locator_tb;
   import prl_pkg::*;

   localparam int NSET = 8;
   localparam int NPOLY = 16;
   localparam int NROW = 16;
   localparam int ONE = 65536;                 // 1.0 in q16.16
   localparam int IDLE_LIMIT = 40000;          // cycles with no item moving
   localparam int SETTLE = 1200;               // beyond worst locate latency
   localparam logic [1:0] ADDR_NUMBER_OF_SETS = 2'd0;

   typedef struct {
      opcode_type  op;
      logic [2:0]  set_index;
      logic [3:0]  poly_index;
      logic [3:0]  row_index;
      logic signed [31:0] v [4];
      logic signed [31:0] row_bound;
      logic        row_enable;
      logic [4:0]  poly_count;
   } region_req_t;

   typedef struct {
      logic [2:0]  found_set;
      logic [3:0]  found_poly;
      logic        found;
      decided_type decided_by;
   } region_rsp_t;

   // mirror of the region table and the locate rule
   class locate_scoreboard;
      logic signed [31:0] coef [NSET][NPOLY][NROW][4];
      logic signed [31:0] bound [NSET][NPOLY][NROW];
      bit en [NSET][NPOLY][NROW];
      int poly_total [NSET];
      int sets_cfg;
      region_rsp_t locate_q [$];
      int errors;

      function void clear();
         foreach (en[s, p, r]) en[s][p][r] = 0;
         foreach (poly_total[s]) poly_total[s] = 0;
         sets_cfg = 0;
         errors = 0;
      endfunction

      function int live_sets();
         return (sets_cfg > NSET) ? NSET : sets_cfg;
      endfunction

      function bit inside_poly(int s, int p, logic signed [31:0] x [4]);
         logic signed [67:0] acc;
         logic signed [67:0] rhs;
         longint prod;
         if (s < 0 || p < 0 || s >= live_sets() || p >= poly_total[s]) return 0;
         for (int r = 0; r < NROW; r++) begin
            if (en[s][p][r]) begin
               acc = 0;
               for (int d = 0; d < 4; d++) begin
                  prod = longint'(coef[s][p][r][d]) * longint'(x[d]);
                  acc = acc + prod;
               end
               rhs = longint'(bound[s][p][r]) <<< 16;
               if (acc > rhs) return 0;
            end
         end
         return 1;
      endfunction

      function void note_item(region_req_t it);
         region_rsp_t e;
         int s, p;
         s = it.set_index;
         p = it.poly_index;
         case (it.op)
            OP_ROW: begin
               for (int d = 0; d < 4; d++) coef[s][p][it.row_index][d] = it.v[d];
               bound[s][p][it.row_index] = it.row_bound;
               en[s][p][it.row_index] = it.row_enable;
            end
            OP_COUNT: poly_total[s] = (it.poly_count > NPOLY) ? NPOLY : it.poly_count;
            OP_LOCATE: begin
               e.found_set = it.set_index;
               e.found_poly = it.poly_index;
               e.found = 1'b0;
               e.decided_by = BY_NONE;
               if (inside_poly(s, p, it.v)) begin
                  e.found = 1'b1;
                  e.decided_by = BY_CURRENT;
               end else if (s > 0 && inside_poly(s - 1, p, it.v)) begin
                  e.found_set = 3'(s - 1);
                  e.found = 1'b1;
                  e.decided_by = BY_PREV_SET;
               end else if (p > 0 && inside_poly(s, p - 1, it.v)) begin
                  e.found_poly = 4'(p - 1);
                  e.found = 1'b1;
                  e.decided_by = BY_PREV_POLY;
               end else begin
                  for (int i = 0; i < live_sets() && !e.found; i++)
                     for (int j = 0; j < poly_total[i] && !e.found; j++)
                        if (inside_poly(i, j, it.v)) begin
                           e.found_set = 3'(i);
                           e.found_poly = 4'(j);
                           e.found = 1'b1;
                           e.decided_by = BY_SEARCH;
                        end
               end
               locate_q = {locate_q, e};
            end
            default: ;
         endcase
      endfunction

      function void check_result(region_rsp_t got);
         region_rsp_t e;
         if (locate_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            errors++;
            return;
         end
         e = locate_q.pop_front();
         if (got.found_set !== e.found_set) begin
            $display("%0t: found_set expected %0d actual %0d", $time, e.found_set,
               got.found_set);
            errors++;
         end
         if (got.found_poly !== e.found_poly) begin
            $display("%0t: found_poly expected %0d actual %0d", $time, e.found_poly,
               got.found_poly);
            errors++;
         end
         if (got.found !== e.found) begin
            $display("%0t: found expected %0d actual %0d", $time, e.found, got.found);
            errors++;
         end
         if (got.decided_by !== e.decided_by) begin
            $display("%0t: decided_by expected %0d actual %0d", $time, e.decided_by,
               got.decided_by);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   prl_req_if req ();
   prl_rsp_if rsp ();

   locate_scoreboard board;
   bit burst;          // no idling on either side while set
   int idle_cycles;

   polyhedral_region_locator u_top (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // watchdog: a stuck handshake ends the run
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function int draw_gap();
      return burst ? 0 : $urandom_range(0, 11);
   endfunction

   // result side: random stalls, every accepted result goes to the checker
   initial begin
      region_rsp_t got;
      int stall;
      rsp.ready = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp.ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1;
         do @(posedge clock); while (!rsp.valid);
         got.found_set = rsp.found_set;
         got.found_poly = rsp.found_poly;
         got.found = rsp.found;
         got.decided_by = decided_type'(rsp.decided_by);
         board.check_result(got);
      end
   end

   task automatic send_item(region_req_t it);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1;
      req.opcode <= it.op;
      req.set_index <= it.set_index;
      req.poly_index <= it.poly_index;
      req.row_index <= it.row_index;
      req.value_0 <= it.v[0];
      req.value_1 <= it.v[1];
      req.value_2 <= it.v[2];
      req.value_3 <= it.v[3];
      req.row_bound <= it.row_bound;
      req.row_enable <= it.row_enable;
      req.poly_count <= it.poly_count;
      do @(posedge clock); while (!req.ready);
      board.note_item(it);
   endtask

   // item builders
   function automatic region_req_t row_item(int s, int p, int r, int a0, int a1, int a2,
      int a3, int b, bit on);
      region_req_t it;
      it.op = OP_ROW;
      it.set_index = 3'(s);
      it.poly_index = 4'(p);
      it.row_index = 4'(r);
      it.v[0] = a0;
      it.v[1] = a1;
      it.v[2] = a2;
      it.v[3] = a3;
      it.row_bound = b;
      it.row_enable = on;
      it.poly_count = 5'($urandom);
      return it;
   endfunction

   function automatic region_req_t count_item(int s, int n);
      region_req_t it;
      it = row_item(s, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, 1'($urandom));
      it.op = OP_COUNT;
      it.poly_count = 5'(n);
      return it;
   endfunction

   function automatic region_req_t locate_item(int s, int p, int x0, int x1, int x2, int x3);
      region_req_t it;
      it = row_item(s, p, $urandom, x0, x1, x2, x3, $urandom, 1'($urandom));
      it.op = OP_LOCATE;
      return it;
   endfunction

   function automatic int near_val(int span);
      return $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   // mostly well-formed loads and locates on small tables, some noise
   function automatic region_req_t random_item();
      region_req_t it;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 62)
         it = locate_item($urandom_range(0, 7), $urandom_range(0, 5), near_val(3 * ONE),
            near_val(3 * ONE), near_val(3 * ONE), near_val(3 * ONE));
      else if (pick < 84)
         it = row_item($urandom_range(0, 7), $urandom_range(0, 5), $urandom_range(0, 15),
            near_val(ONE), near_val(ONE), near_val(ONE), near_val(ONE),
            near_val(2 * ONE), $urandom_range(0, 3) != 0);
      else if (pick < 92)
         it = count_item($urandom_range(0, 7), $urandom_range(1, 6));
      else begin
         // raw noise, any opcode and any bits
         it = row_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, 1'($urandom));
         it.op = opcode_type'(2'($urandom_range(0, 3)));
         it.poly_count = 5'($urandom);
      end
      return it;
   endfunction

   // drop valid so a held item is not taken twice, then wait for every result
   task automatic drain();
      req.valid <= 0;
      @(posedge clock);
      while (board.locate_q.size() != 0) @(posedge clock);
   endtask

   // register writes only with the block idle
   task automatic write_sets(int n);
      drain();
      repeat (SETTLE) @(posedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= ADDR_NUMBER_OF_SETS;
      csr_pwdata <= n;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      board.sets_cfg = n & 15;
   endtask

   task automatic random_phase(int sets, int n);
      write_sets(sets);
      for (int i = 0; i < n; i++) begin
         if (i % 20 == 0) burst = ($urandom_range(0, 3) == 0);
         // sender holds off once per phase until all results are back
         if (i == n / 2) drain();
         send_item(random_item());
      end
   endtask

   initial begin
      board = new();
      board.clear();
      burst = 0;
      idle_cycles = 0;
      reset = 1;
      req.valid = 0;
      req.opcode = OP_NONE;
      req.set_index = 0;
      req.poly_index = 0;
      req.row_index = 0;
      req.value_0 = 0;
      req.value_1 = 0;
      req.value_2 = 0;
      req.value_3 = 0;
      req.row_bound = 0;
      req.row_enable = 0;
      req.poly_count = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // no sets configured after reset: nothing can be found
      send_item(locate_item(0, 0, 0, 0, 0, 0));
      send_item(locate_item(7, 15, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000));

      write_sets(8);
      send_item(count_item(0, 16));
      send_item(count_item(1, 16));
      send_item(count_item(7, 31));              // saturates to the table size
      send_item(row_item(1, 2, 0, ONE, 0, 0, 0, ONE, 1));            // x0 <= 1
      send_item(row_item(0, 2, 0, -ONE, 0, 0, 0, -2 * ONE, 1));      // x0 >= 2
      send_item(row_item(1, 1, 0, 0, ONE, 0, 0, 0, 1));              // x1 <= 0
      send_item(row_item(7, 15, 15, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
         32'h7fffffff, 32'h80000000, 1));
      send_item(row_item(7, 14, 14, 32'h80000000, 32'h80000000, 32'h80000000,
         32'h80000000, 32'h7fffffff, 0));                            // disabled row
      send_item(locate_item(1, 2, 0, 0, 0, 0));                      // current hit
      send_item(locate_item(1, 2, 3 * ONE, 0, 0, 0));                // previous set
      send_item(locate_item(1, 2, 98304, -ONE, 0, 0));               // previous polyhedron
      send_item(locate_item(1, 2, 98304, ONE, 0, 0));                // full search
      send_item(locate_item(7, 15, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      send_item(locate_item(0, 2, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
      send_item(count_item(2, 0));
      send_item(locate_item(2, 0, 0, 0, 0, 0));                      // empty set, found in the previous set
      begin
         region_req_t junk;
         junk = random_item();
         junk.op = OP_NONE;
         send_item(junk);
      end

      // give the only polyhedron of set 0 a blocking row so locates can miss
      write_sets(1);
      send_item(count_item(0, 1));
      send_item(row_item(0, 0, 3, 0, 0, ONE, 0, -ONE, 1));           // x2 <= -1
      send_item(locate_item(0, 0, 0, 0, 0, 0));                      // none

      random_phase(8, 85);
      random_phase(15, 65);
      random_phase(3, 60);
      random_phase(5, 60);

      drain();
      repeat (SETTLE) @(posedge clock);
      if (board.errors == 0 && board.locate_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
